// ===== rtl/stx_pkg.sv =====
package stx_pkg;

	// default frame store depth
	localparam int MSG_LEN_DEF = 16;

	// configuration register indexes
	localparam logic [1:0] REG_START_CODE = 2'd0;
	localparam logic [1:0] REG_END_CODE   = 2'd1;
	localparam logic [1:0] REG_HOLDOFF    = 2'd2;

	// register reset values
	localparam logic [7:0]  START_CODE_RST = 8'h02;
	localparam logic [7:0]  END_CODE_RST   = 8'h03;
	localparam logic [15:0] HOLDOFF_RST    = 16'd1000;

endpackage

// ===== rtl/stx_ram.sv =====
module stx_ram #(
	parameter int DEPTH = stx_pkg::MSG_LEN_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/stx_etx_frame_receiver.sv =====
// Framed byte receiver. Items are either a received byte (func 0) or one time
// tick (func 1). The block hunts for start_code, stores the following bytes in
// an internal frame memory of MSG_LEN entries and, on end_code, plays the frame
// back as one beat per payload byte with last set on the final one; a frame
// with no payload gives one beat with empty_frame and last set and out_byte
// zero. A frame that reaches MSG_LEN bytes without end_code is dropped with no
// output and hunting restarts. After each frame, received bytes are discarded
// until more than holdoff_ticks ticks have been seen. Input items are taken at
// one per cycle with two exceptions. During playback the input is held while
// the frame memory is read, one read per payload byte, and until the last
// read has left the read stage, longer if the output side stalls. While
// collecting, every item is held while the output register carries a beat that
// has not been taken. Configuration writes are meant for an idle block.
module stx_etx_frame_receiver #(
	parameter int MSG_LEN = stx_pkg::MSG_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  rx_byte,
	// result beats
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        empty_frame,
	output logic        last
);

	localparam int AW = $clog2(MSG_LEN);
	localparam int FW = $clog2(MSG_LEN + 1);

	// receiver modes
	localparam logic [1:0] MODE_HUNT    = 2'd0;
	localparam logic [1:0] MODE_COLLECT = 2'd1;
	localparam logic [1:0] MODE_HOLD    = 2'd2;
	localparam logic [1:0] MODE_DRAIN   = 2'd3;

	logic [7:0]    start_q;
	logic [7:0]    end_q;
	logic [15:0]   holdoff_q;

	logic [1:0]    mode_q;
	logic [FW-1:0] fill_q;
	logic [16:0]   elapsed_q;
	logic [FW-1:0] cnt_q;
	logic [AW-1:0] rd_idx_q;

	logic          valid_s1;
	logic          last_s1;

	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          empty_q;
	logic          last_q;

	logic          out_free;
	logic          in_acc;
	logic          is_byte;
	logic          is_tick;
	logic          end_hit;
	logic          store;
	logic [FW-1:0] fill_inc;
	logic [16:0]   elapsed_nxt;
	logic          issue;
	logic          rd_last;
	logic [7:0]    rdata;

	// output register frees up when empty or being taken
	assign out_free = !out_valid_q || !out_stall;

	// hold the input during playback, and while collecting hold every item (it may
	// be an end code) while the output register is occupied and stalled
	assign in_stall = (mode_q == MODE_DRAIN) || valid_s1 ||
		((mode_q == MODE_COLLECT) && !out_free);

	assign in_acc  = in_valid && !in_stall;
	assign is_byte = in_acc && !func;
	assign is_tick = in_acc && func;

	assign end_hit  = is_byte && (mode_q == MODE_COLLECT) && (rx_byte == end_q);
	assign store    = is_byte && (mode_q == MODE_COLLECT) && (rx_byte != end_q);
	assign fill_inc = fill_q + 1'b1;

	// saturating tick count
	assign elapsed_nxt = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;

	// playback read issue
	assign issue   = (mode_q == MODE_DRAIN) && out_free;
	assign rd_last = ({{(FW - AW){1'b0}}, rd_idx_q} + 1'b1) == cnt_q;

	stx_ram #(
		.DEPTH (MSG_LEN),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (store),
		.waddr (fill_q[AW-1:0]),
		.wdata (rx_byte),
		.re    (issue),
		.raddr (rd_idx_q),
		.rdata (rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= stx_pkg::START_CODE_RST;
			end_q     <= stx_pkg::END_CODE_RST;
			holdoff_q <= stx_pkg::HOLDOFF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				stx_pkg::REG_START_CODE: start_q   <= cfg_wdata[7:0];
				stx_pkg::REG_END_CODE:   end_q     <= cfg_wdata[7:0];
				stx_pkg::REG_HOLDOFF:    holdoff_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// frame control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_HUNT;
			fill_q    <= '0;
			elapsed_q <= '0;
			cnt_q     <= '0;
			rd_idx_q  <= '0;
		end else begin
			unique case (mode_q)
				MODE_HUNT: begin
					if (is_byte && (rx_byte == start_q)) begin
						mode_q <= MODE_COLLECT;
					end
				end
				MODE_COLLECT: begin
					if (end_hit) begin
						fill_q    <= '0;
						elapsed_q <= '0;
						cnt_q     <= fill_q;
						rd_idx_q  <= '0;
						// empty frame goes straight out through the output register
						mode_q    <= (fill_q == '0) ? MODE_HOLD : MODE_DRAIN;
					end else if (store) begin
						// frame full without end code: drop it
						if (fill_inc == FW'(MSG_LEN)) begin
							fill_q <= '0;
							mode_q <= MODE_HUNT;
						end else begin
							fill_q <= fill_inc;
						end
					end
				end
				MODE_HOLD: begin
					if (is_tick) begin
						elapsed_q <= elapsed_nxt;
						if (elapsed_nxt > {1'b0, holdoff_q}) begin
							mode_q <= MODE_HUNT;
						end
					end
				end
				MODE_DRAIN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						if (rd_last) begin
							mode_q <= MODE_HOLD;
						end
					end
				end
			endcase
		end
	end

	// read stage: valid while memory data is pending
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (out_free) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			last_s1 <= rd_last;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 || (end_hit && (fill_q == '0));
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (valid_s1) begin
				out_byte_q <= rdata;
				empty_q    <= 1'b0;
				last_q     <= last_s1;
			end else begin
				// empty frame beat
				out_byte_q <= 8'h00;
				empty_q    <= 1'b1;
				last_q     <= 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign empty_frame = empty_q;
	assign last        = last_q;

endmodule
